[src/crx_pkg.sv]
// Package for the CAN receive identifier filter: beat types, codes, constants,
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package crx_pkg;

   localparam int unsigned CRX_TABLE_DEPTH    = 16;
   localparam int unsigned CRX_MAX_DATA_BYTES = 8;

   // input kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_FIRST = 2'd1;
   localparam logic [1:0] KIND_NEXT  = 2'd2;

   // result kinds
   localparam logic [1:0] OUT_ID   = 2'd0;
   localparam logic [1:0] OUT_LEN  = 2'd1;
   localparam logic [1:0] OUT_DATA = 2'd2;

   localparam logic [4:0]  NO_MATCH_SLOT = 5'd16;
   localparam logic [31:0] EXT_FLAG      = 32'h8000_0000;
   localparam logic [7:0]  EXIDE_MASK    = 8'h08;
   localparam logic [7:0]  SIDL_EID_MASK = 8'h03;

   // register byte address
   localparam logic [1:0] CSR_TABLE_COUNT_ADDR = 2'd0;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  entry_index;
      logic [31:0] entry_id;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [4:0]  slot;
      logic [31:0] message_id;
      logic [2:0]  byte_pos;
      logic [7:0]  byte_value;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SIDL,
      PH_EID8,
      PH_EID0,
      PH_LEN,
      PH_DATA
   } parse_phase_type;

   typedef enum logic [1:0] {
      SRCH_IDLE,
      SRCH_READ,
      SRCH_CMP
   } srch_state_type;

   typedef struct packed {
      logic wr_entry;    // store req entry_id in the table
      logic msg_start;   // SIDH beat: restart the message
      logic sidl_step;
      logic eid8_step;
      logic eid0_step;   // also clears the search counter
      logic rd_entry;    // read table at search counter
      logic next_entry;  // advance search counter
      logic id_done;     // load identifier beat into output register
      logic id_hit;      // with id_done: match at search counter
      logic len_step;    // length beat into output register
      logic data_step;   // data beat into output register
   } crx_cmd_type;

   typedef struct packed {
      logic srch_done;   // counter reached the active table size
      logic entry_hit;   // table read data equals assembled id
      logic len_zero;    // incoming length nibble is zero
      logic data_last;   // at most one data byte left
   } crx_sts_type;

endpackage
`default_nettype wire

[src/crx_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone, no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module crx_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[src/crx_dpath.sv]
// Datapath: identifier assembly, table search counter, data counters and the
// result register. Uses crx_pkg and crx_ram; driven by crx_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module crx_dpath #(
   parameter int unsigned TABLE_DEPTH = crx_pkg::CRX_TABLE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire crx_pkg::req_type     req_data,
   input  wire logic [4:0]           table_count,
   input  wire crx_pkg::crx_cmd_type cmd,
   output crx_pkg::crx_sts_type      sts,
   output crx_pkg::rsp_type          rsp_data
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned SW = (AW > 5) ? AW : 5;

   logic [31:0]      id_accum_ff, id_accum_in;
   logic             ext_seen_ff, ext_seen_in;
   logic [4:0]       match_slot_ff, match_slot_in;
   logic [3:0]       data_left_ff, data_left_in;
   logic [2:0]       data_pos_ff, data_pos_in;
   logic [SW-1:0]    srch_cnt_ff, srch_cnt_in;
   crx_pkg::rsp_type rsp_ff, rsp_in;

   logic [SW-1:0] srch_limit;
   logic [6:0]    entry_index_wide;
   logic          entry_in_range;
   logic [31:0]   rd_data;
   logic [7:0]    rx_byte;
   logic [3:0]    len_clamped;
   logic [4:0]    id_slot;

   assign rx_byte = req_data.rx_byte;

   // active table size: register value, limited to the depth
   always_comb begin
      if (7'(table_count) > 7'(TABLE_DEPTH)) begin
         srch_limit = SW'(TABLE_DEPTH);
      end else begin
         srch_limit = SW'(table_count);
      end
   end

   assign entry_index_wide = 7'(req_data.entry_index);
   assign entry_in_range   = entry_index_wide < 7'(TABLE_DEPTH);

   crx_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_DEPTH)
   ) u_id_table (
      .clock   (clock),
      .wr_en   (cmd.wr_entry && entry_in_range),
      .wr_addr (entry_index_wide[AW-1:0]),
      .wr_data (req_data.entry_id),
      .rd_en   (cmd.rd_entry),
      .rd_addr (srch_cnt_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      if (rx_byte[3:0] > 4'(crx_pkg::CRX_MAX_DATA_BYTES)) begin
         len_clamped = 4'(crx_pkg::CRX_MAX_DATA_BYTES);
      end else begin
         len_clamped = rx_byte[3:0];
      end
   end

   assign id_slot = cmd.id_hit ? srch_cnt_ff[4:0] : crx_pkg::NO_MATCH_SLOT;

   always_comb begin
      id_accum_in   = id_accum_ff;
      ext_seen_in   = ext_seen_ff;
      match_slot_in = match_slot_ff;
      data_left_in  = data_left_ff;
      data_pos_in   = data_pos_ff;
      srch_cnt_in   = srch_cnt_ff;
      rsp_in        = rsp_ff;

      if (cmd.msg_start) begin
         id_accum_in   = 32'(rx_byte);
         ext_seen_in   = 1'b0;
         match_slot_in = crx_pkg::NO_MATCH_SLOT;
         data_left_in  = '0;
         data_pos_in   = '0;
      end
      if (cmd.sidl_step) begin
         ext_seen_in = (rx_byte & crx_pkg::EXIDE_MASK) != 8'd0;
         if ((rx_byte & crx_pkg::EXIDE_MASK) != 8'd0) begin
            id_accum_in = 32'({id_accum_ff[7:0], rx_byte[7:5],
                               rx_byte[1:0] & crx_pkg::SIDL_EID_MASK[1:0]});
         end else begin
            id_accum_in = 32'({id_accum_ff[7:0], rx_byte[7:5]});
         end
      end
      if (cmd.eid8_step && ext_seen_ff) begin
         id_accum_in = {id_accum_ff[23:0], rx_byte};
      end
      if (cmd.eid0_step) begin
         srch_cnt_in = '0;
         if (ext_seen_ff) begin
            id_accum_in = {id_accum_ff[23:0], rx_byte} | crx_pkg::EXT_FLAG;
         end
      end
      if (cmd.next_entry) begin
         srch_cnt_in = srch_cnt_ff + SW'(1);
      end
      if (cmd.id_done) begin
         match_slot_in     = id_slot;
         rsp_in.out_kind   = crx_pkg::OUT_ID;
         rsp_in.slot       = id_slot;
         rsp_in.message_id = id_accum_ff;
         rsp_in.byte_pos   = '0;
         rsp_in.byte_value = '0;
         rsp_in.last       = !cmd.id_hit;
      end
      if (cmd.len_step) begin
         data_left_in      = len_clamped;
         data_pos_in       = '0;
         rsp_in.out_kind   = crx_pkg::OUT_LEN;
         rsp_in.slot       = match_slot_ff;
         rsp_in.message_id = id_accum_ff;
         rsp_in.byte_pos   = '0;
         rsp_in.byte_value = rx_byte;
         rsp_in.last       = len_clamped == 4'd0;
      end
      if (cmd.data_step) begin
         data_pos_in       = data_pos_ff + 3'd1;
         if (data_left_ff != 4'd0) begin
            data_left_in = data_left_ff - 4'd1;
         end
         rsp_in.out_kind   = crx_pkg::OUT_DATA;
         rsp_in.slot       = match_slot_ff;
         rsp_in.message_id = id_accum_ff;
         rsp_in.byte_pos   = data_pos_ff;
         rsp_in.byte_value = rx_byte;
         rsp_in.last       = data_left_ff <= 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_accum_ff   <= '0;
         ext_seen_ff   <= 1'b0;
         match_slot_ff <= crx_pkg::NO_MATCH_SLOT;
         data_left_ff  <= '0;
         data_pos_ff   <= '0;
         srch_cnt_ff   <= '0;
      end else begin
         id_accum_ff   <= id_accum_in;
         ext_seen_ff   <= ext_seen_in;
         match_slot_ff <= match_slot_in;
         data_left_ff  <= data_left_in;
         data_pos_ff   <= data_pos_in;
         srch_cnt_ff   <= srch_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign sts.srch_done = srch_cnt_ff == srch_limit;
   assign sts.entry_hit = rd_data == id_accum_ff;
   assign sts.len_zero  = len_clamped == 4'd0;
   assign sts.data_last = data_left_ff <= 4'd1;

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

[src/crx_ctrl.sv]
// Controller: input handshake, parse phase, table search sequencing and the
// result valid flag. Uses crx_pkg; drives crx_dpath through commands.
`timescale 1ns / 1ps
`default_nettype none
module crx_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_kind,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire crx_pkg::crx_sts_type sts,
   output crx_pkg::crx_cmd_type      cmd
);

   crx_pkg::parse_phase_type phase_ff, phase_in;
   crx_pkg::srch_state_type  srch_ff, srch_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     req_accept;
   logic                     rsp_take;

   // busy while searching, or while a held result is not being drained
   assign req_stall  = (srch_ff != crx_pkg::SRCH_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;

   // next state
   always_comb begin
      phase_in     = phase_ff;
      srch_in      = srch_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;

      case (srch_ff)
         crx_pkg::SRCH_IDLE: begin
            if (req_accept) begin
               case (req_kind)
                  crx_pkg::KIND_FIRST: begin
                     phase_in = crx_pkg::PH_SIDL;
                  end
                  crx_pkg::KIND_NEXT: begin
                     case (phase_ff)
                        crx_pkg::PH_SIDL: phase_in = crx_pkg::PH_EID8;
                        crx_pkg::PH_EID8: phase_in = crx_pkg::PH_EID0;
                        crx_pkg::PH_EID0: srch_in  = crx_pkg::SRCH_READ;
                        crx_pkg::PH_LEN: begin
                           rsp_valid_in = 1'b1;
                           phase_in = sts.len_zero ? crx_pkg::PH_IDLE : crx_pkg::PH_DATA;
                        end
                        crx_pkg::PH_DATA: begin
                           rsp_valid_in = 1'b1;
                           if (sts.data_last) begin
                              phase_in = crx_pkg::PH_IDLE;
                           end
                        end
                        default: phase_in = phase_ff;
                     endcase
                  end
                  default: phase_in = phase_ff;
               endcase
            end
         end
         crx_pkg::SRCH_READ: begin
            if (sts.srch_done) begin
               srch_in      = crx_pkg::SRCH_IDLE;
               phase_in     = crx_pkg::PH_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               srch_in = crx_pkg::SRCH_CMP;
            end
         end
         crx_pkg::SRCH_CMP: begin
            if (sts.entry_hit) begin
               srch_in      = crx_pkg::SRCH_IDLE;
               phase_in     = crx_pkg::PH_LEN;
               rsp_valid_in = 1'b1;
            end else begin
               srch_in = crx_pkg::SRCH_READ;
            end
         end
         default: srch_in = crx_pkg::SRCH_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      case (srch_ff)
         crx_pkg::SRCH_IDLE: begin
            if (req_accept) begin
               case (req_kind)
                  crx_pkg::KIND_LOAD:  cmd.wr_entry  = 1'b1;
                  crx_pkg::KIND_FIRST: cmd.msg_start = 1'b1;
                  crx_pkg::KIND_NEXT: begin
                     case (phase_ff)
                        crx_pkg::PH_SIDL: cmd.sidl_step = 1'b1;
                        crx_pkg::PH_EID8: cmd.eid8_step = 1'b1;
                        crx_pkg::PH_EID0: cmd.eid0_step = 1'b1;
                        crx_pkg::PH_LEN:  cmd.len_step  = 1'b1;
                        crx_pkg::PH_DATA: cmd.data_step = 1'b1;
                        default:          cmd = '0;
                     endcase
                  end
                  default: cmd = '0;
               endcase
            end
         end
         crx_pkg::SRCH_READ: begin
            if (sts.srch_done) begin
               cmd.id_done = 1'b1;
            end else begin
               cmd.rd_entry = 1'b1;
            end
         end
         crx_pkg::SRCH_CMP: begin
            if (sts.entry_hit) begin
               cmd.id_done = 1'b1;
               cmd.id_hit  = 1'b1;
            end else begin
               cmd.next_entry = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= crx_pkg::PH_IDLE;
         srch_ff      <= crx_pkg::SRCH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         srch_ff      <= srch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[src/can_rx_id_match_parser.sv]
// CAN receive identifier filter, top level: APB register, controller and
// datapath. Uses crx_pkg, crx_ctrl, crx_dpath (which holds crx_ram).
// Usage
//   req channel (req_valid/req_stall/req_data): one beat per buffer byte or
//   table load. kind LOAD writes entry_id into slot entry_index (ignored past
//   the table depth); kind FIRST carries SIDH and restarts the parser; kind
//   NEXT carries SIDL, EID8, EID0, length, then data bytes.
//   rsp channel (rsp_valid/rsp_stall/rsp_data): identifier result after
//   EID0 (slot 16 = no match, last set), then on a match the length beat and
//   one beat per data byte, the final one with last set.
//   APB: table_count at address 0 (active table entries); write only when idle.
// Sequencing
//   Loads, SIDH, SIDL and EID8 give no beat. Length and data beats appear
//   in the cycle after acceptance. The EID0 beat starts a search over the
//   table RAM that steps through the entries in order, a read and then a
//   compare for each, and stops at the first hit or after the last active
//   entry. No beat is taken during a search.
//   A finished result sits in an output register; a new beat is still taken
//   unless that register is full and rsp_stall is high.
// Reset: parser idle, table_count cleared; table contents undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module can_rx_id_match_parser #(
   parameter int unsigned TABLE_DEPTH = crx_pkg::CRX_TABLE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // input beats
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire crx_pkg::req_type req_data,
   // result beats
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output crx_pkg::rsp_type      rsp_data,
   // APB register port
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [1:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [4:0]           table_count_ff, table_count_in;
   logic                 csr_write;
   crx_pkg::crx_cmd_type cmd;
   crx_pkg::crx_sts_type sts;

   // register port: zero wait states
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr == crx_pkg::CSR_TABLE_COUNT_ADDR);

   assign table_count_in = csr_write ? pwdata[4:0] : table_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_count_ff <= '0;
      end else begin
         table_count_ff <= table_count_in;
      end
   end

   assign prdata = (paddr == crx_pkg::CSR_TABLE_COUNT_ADDR) ? 32'(table_count_ff) : 32'd0;

   // sequencing: handshakes, parse phase, search steps
   crx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // identifier assembly, table RAM and result register
   crx_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .table_count (table_count_ff),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

[sim/can_rx_id_match_parser_tb.sv]
// Self-checking testbench for can_rx_id_match_parser: random frames, table loads and
// table_count settings, checked beat by beat against an in-bench filter model.
// Depends on crx_pkg and the RTL under src.
`timescale 1ns / 1ps
module can_rx_id_match_parser_tb;

   localparam logic [1:0]  KIND_UNUSED    = 2'd3;   // block must drop it
   localparam int unsigned SETTLE_CYCLES  = 2 * crx_pkg::CRX_TABLE_DEPTH + 8;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned PHASE_BEATS    = 160;
   localparam int unsigned MAX_SHOWN      = 10;
   localparam logic [63:0] BOUNDARY_DATA  = 64'h00FF_55AA_0180_7FFE;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_RUNS
   } stall_mode_type;

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_valid  = 1'b0;
   logic             req_stall;
   crx_pkg::req_type req_data   = '0;
   logic             rsp_valid;
   logic             rsp_stall  = 1'b0;
   crx_pkg::rsp_type rsp_data;
   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [1:0]  paddr   = '0;
   logic [31:0] pwdata  = '0;
   logic [31:0] prdata;
   logic        pready;

   can_rx_id_match_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Filter model: table, parser state and register copy, advanced once
   // per accepted input beat. Outputs land in match_reports.
   // ------------------------------------------------------------------
   logic [31:0]               id_table [crx_pkg::CRX_TABLE_DEPTH];
   crx_pkg::parse_phase_type  cur_phase   = crx_pkg::PH_IDLE;
   logic [31:0]               id_acc      = '0;
   logic                      ext_frame   = 1'b0;
   logic [4:0]                hit_slot    = crx_pkg::NO_MATCH_SLOT;
   logic [3:0]                bytes_left  = '0;
   logic [2:0]                byte_idx    = '0;
   logic [4:0]                table_count_cfg = '0;   // reset value of the register
   crx_pkg::rsp_type          match_reports [$];

   // stimulus side: what the table will hold once the backlog drains
   logic [31:0]               gen_table [crx_pkg::CRX_TABLE_DEPTH];
   crx_pkg::req_type          rx_backlog [$];

   // run statistics and error tally
   int unsigned mismatches = 0;
   int unsigned beats_in = 0, beats_out = 0;
   int unsigned id_hits = 0, id_misses = 0, data_beats = 0;
   int unsigned sizes_used = 0, drain_pauses = 0;
   bit          hung = 1'b0;

   initial begin
      for (int i = 0; i < crx_pkg::CRX_TABLE_DEPTH; i++) begin
         id_table[i]  = '0;
         gen_table[i] = '0;
      end
   end

   function automatic crx_pkg::rsp_type report(input logic [1:0] kind,
                                               input logic [2:0] pos,
                                               input logic [7:0] val, input logic fin);
      crx_pkg::rsp_type r;
      r.out_kind   = kind;
      r.slot       = hit_slot;
      r.message_id = id_acc;
      r.byte_pos   = pos;
      r.byte_value = val;
      r.last       = fin;
      return r;
   endfunction

   function automatic string beat_text(input crx_pkg::rsp_type r);
      return $sformatf("kind %0d slot %0d id %h pos %0d byte %h last %0d",
                       r.out_kind, r.slot, r.message_id, r.byte_pos, r.byte_value,
                       r.last);
   endfunction

   task automatic parse_and_match(input crx_pkg::req_type beat);
      logic [3:0]  cnt;
      int unsigned lim;
      case (beat.kind)
         crx_pkg::KIND_LOAD: id_table[beat.entry_index] = beat.entry_id;
         crx_pkg::KIND_FIRST: begin
            // SIDH restarts the frame, abandoning anything in flight
            id_acc     = {24'd0, beat.rx_byte};
            ext_frame  = 1'b0;
            hit_slot   = crx_pkg::NO_MATCH_SLOT;
            bytes_left = '0;
            byte_idx   = '0;
            cur_phase  = crx_pkg::PH_SIDL;
         end
         crx_pkg::KIND_NEXT: begin
            case (cur_phase)
               crx_pkg::PH_SIDL: begin
                  id_acc    = {21'd0, id_acc[7:0], beat.rx_byte[7:5]};
                  ext_frame = (beat.rx_byte & crx_pkg::EXIDE_MASK) != 8'd0;
                  if (ext_frame) id_acc = {id_acc[29:0], beat.rx_byte[1:0]};
                  cur_phase = crx_pkg::PH_EID8;
               end
               crx_pkg::PH_EID8: begin
                  // standard frames swallow EID8/EID0 unchanged
                  if (ext_frame) id_acc = {id_acc[23:0], beat.rx_byte};
                  cur_phase = crx_pkg::PH_EID0;
               end
               crx_pkg::PH_EID0: begin
                  if (ext_frame) id_acc = {id_acc[23:0], beat.rx_byte} | crx_pkg::EXT_FLAG;
                  lim = (table_count_cfg > crx_pkg::CRX_TABLE_DEPTH)
                        ? crx_pkg::CRX_TABLE_DEPTH : table_count_cfg;
                  hit_slot = crx_pkg::NO_MATCH_SLOT;
                  for (int i = 0; i < lim; i++) begin
                     if (id_table[i] == id_acc) begin
                        hit_slot = 5'(i);   // lowest slot wins
                        break;
                     end
                  end
                  if (hit_slot == crx_pkg::NO_MATCH_SLOT) begin
                     id_misses++;
                     cur_phase = crx_pkg::PH_IDLE;
                  end else begin
                     id_hits++;
                     cur_phase = crx_pkg::PH_LEN;
                  end
                  match_reports.push_back(report(crx_pkg::OUT_ID, 3'd0, 8'd0,
                                                 hit_slot == crx_pkg::NO_MATCH_SLOT));
               end
               crx_pkg::PH_LEN: begin
                  cnt = beat.rx_byte[3:0];
                  if (cnt > crx_pkg::CRX_MAX_DATA_BYTES) begin
                     cnt = 4'(crx_pkg::CRX_MAX_DATA_BYTES);
                  end
                  bytes_left = cnt;
                  byte_idx   = '0;
                  cur_phase  = (cnt != 4'd0) ? crx_pkg::PH_DATA : crx_pkg::PH_IDLE;
                  match_reports.push_back(report(crx_pkg::OUT_LEN, 3'd0, beat.rx_byte,
                                                 cnt == 4'd0));
               end
               crx_pkg::PH_DATA: begin
                  data_beats++;
                  match_reports.push_back(report(crx_pkg::OUT_DATA, byte_idx, beat.rx_byte,
                                                 bytes_left <= 4'd1));
                  byte_idx = byte_idx + 3'd1;
                  if (bytes_left != 4'd0) bytes_left = bytes_left - 4'd1;
                  if (bytes_left == 4'd0) cur_phase = crx_pkg::PH_IDLE;
               end
               default: ;   // idle: stray byte dropped
            endcase
         end
         default: ;   // unused kind dropped
      endcase
   endtask

   // returns 1 while mismatches are still printed in full
   function automatic bit log_mismatch();
      mismatches++;
      return mismatches <= MAX_SHOWN;
   endfunction

   // ------------------------------------------------------------------
   // Monitor: samples both channels at the rising edge, checks result
   // beats first, then feeds the accepted input beat to the model.
   // ------------------------------------------------------------------
   bit               req_taken = 1'b0;
   bit               rsp_taken;
   int unsigned      idle_cycles = 0;
   crx_pkg::rsp_type want_beat;

   always @(posedge clock) begin
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         rsp_taken = rsp_valid && !rsp_stall;
         if (rsp_taken) begin
            beats_out++;
            if (match_reports.size() == 0) begin
               if (log_mismatch())
                  $display("unexpected result beat: %s", beat_text(rsp_data));
            end else begin
               want_beat = match_reports.pop_front();
               if (rsp_data !== want_beat) begin
                  if (log_mismatch()) begin
                     $display("result mismatch: want %s", beat_text(want_beat));
                     $display("                  got %s", beat_text(rsp_data));
                  end
               end
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            beats_in++;
            parse_and_match(req_data);
         end
         // watchdog: nothing moving on either channel for too long
         if (req_taken || rsp_taken) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) hung = 1'b1;
      end
   end

   initial begin
      wait (hung);
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("can_rx_id_match_parser_tb: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------
   // Driver: bursts of random length from rx_backlog with random gaps;
   // now and then holds off until every outstanding result is back.
   // ------------------------------------------------------------------
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;
   bit          drain_wait = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // stalled: beat holds as is
      end else if (drain_wait) begin
         req_valid <= 1'b0;
         if (match_reports.size() == 0) drain_wait = 1'b0;
      end else if (gap_left != 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (rx_backlog.size() != 0) begin
         req_data  <= rx_backlog.pop_front();
         req_valid <= 1'b1;
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // zero gap merges bursts into long unbroken stretches
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (drain_pauses == 0 || $urandom_range(0, 11) == 0) begin
               drain_wait = 1'b1;
               drain_pauses++;
            end
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result side back-pressure in randomly chosen modes: none, light, heavy and runs.
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    mode_left  = 0;
   int unsigned    run_left   = 0;
   bit             run_level  = 1'b0;

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (run_left == 0) begin
               run_left  = $urandom_range(1, 24);
               run_level = ~run_level;
            end
            run_left--;
            rsp_stall <= run_level;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_byte(input logic [1:0] kind, input logic [7:0] b);
      crx_pkg::req_type beat;
      beat.kind        = kind;
      beat.entry_index = 4'($urandom);
      beat.entry_id    = $urandom;
      beat.rx_byte     = b;
      rx_backlog.push_back(beat);
   endtask

   task automatic queue_load(input logic [3:0] idx, input logic [31:0] id);
      crx_pkg::req_type beat;
      beat.kind        = crx_pkg::KIND_LOAD;
      beat.entry_index = idx;
      beat.entry_id    = id;
      beat.rx_byte     = 8'($urandom);
      gen_table[idx]   = id;
      rx_backlog.push_back(beat);
   endtask

   function automatic logic [31:0] random_id();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 5) return {21'd0, 11'($urandom)};
      if (r < 9) return crx_pkg::EXT_FLAG | {3'd0, 29'($urandom)};
      return $urandom;   // may not be encodable at all
   endfunction

   function automatic logic [31:0] table_value();
      if ($urandom_range(0, 6) == 0) begin
         return gen_table[$urandom_range(0, crx_pkg::CRX_TABLE_DEPTH - 1)];
      end
      return random_id();
   endfunction

   // SIDH, SIDL, EID8, EID0 for an identifier; don't-care bits are random
   function automatic logic [31:0] frame_head(input logic [31:0] id);
      logic [7:0] sidl;
      sidl = 8'($urandom);
      if (id[31]) begin
         sidl = {id[20:18], sidl[4], 1'b1, sidl[2], id[17:16]};
         return {id[28:21], sidl, id[15:8], id[7:0]};
      end
      sidl = {id[2:0], sidl[4], 1'b0, sidl[2:0]};
      return {id[10:3], sidl, 8'($urandom), 8'($urandom)};
   endfunction

   task automatic queue_frame(input logic [31:0] id, input bit want_hit, input bit cut);
      logic [7:0]  frame_bytes [13];
      logic [31:0] head;
      logic [7:0]  len_byte;
      int unsigned n, cnt, send;
      head = frame_head(id);
      for (int k = 0; k < 4; k++) frame_bytes[k] = head[31 - 8*k -: 8];
      n = 4;
      len_byte = {4'($urandom), ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                            : 4'($urandom_range(0, 8))};
      // a miss sometimes gets a length byte the parser must drop
      if (want_hit || $urandom_range(0, 4) == 0) begin
         frame_bytes[4] = len_byte;
         n = 5;
      end
      if (want_hit) begin
         cnt = (len_byte[3:0] > crx_pkg::CRX_MAX_DATA_BYTES) ? crx_pkg::CRX_MAX_DATA_BYTES
                                                             : len_byte[3:0];
         for (int k = 0; k < cnt; k++) frame_bytes[5 + k] = 8'($urandom);
         n += cnt;
      end
      send = cut ? $urandom_range(1, n - 1) : n;
      queue_byte(crx_pkg::KIND_FIRST, frame_bytes[0]);
      for (int k = 1; k < send; k++) queue_byte(crx_pkg::KIND_NEXT, frame_bytes[k]);
   endtask

   task automatic queue_random_phase(input int unsigned beats);
      int unsigned pick, top;
      bit          from_table;
      logic [31:0] id;
      while (rx_backlog.size() < beats) begin
         pick = $urandom_range(0, 99);
         top  = (table_count_cfg > crx_pkg::CRX_TABLE_DEPTH) ? crx_pkg::CRX_TABLE_DEPTH
                                                             : table_count_cfg;
         if (pick < 6) begin
            queue_load(4'($urandom), table_value());
         end else if (pick < 10) begin
            queue_byte(($urandom_range(0, 1) != 0) ? KIND_UNUSED : crx_pkg::KIND_NEXT,
                       8'($urandom));
         end else begin
            from_table = (top != 0) && ($urandom_range(0, 99) < 65);
            id = from_table ? gen_table[$urandom_range(0, top - 1)] : random_id();
            queue_frame(id, from_table, pick < 18);   // some frames cut short
         end
      end
   endtask

   // waits until the block is idle: backlog sent, results in, search done
   task automatic settle();
      while (rx_backlog.size() != 0 || req_valid) @(posedge clock);
      while (match_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write of table_count, then a read back of the same register
   task automatic write_table_count(input logic [4:0] v);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= crx_pkg::CSR_TABLE_COUNT_ADDR;
      pwdata  <= {27'd0, v};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      table_count_cfg = v;
      sizes_used++;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[4:0] !== v) begin
         if (log_mismatch())
            $display("table_count read back: want %0d got %0d", v, prdata[4:0]);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   logic [4:0] phase_sizes [6];

   initial begin
      phase_sizes[0] = 5'd16;
      phase_sizes[1] = 5'd31;   // above depth, acts as full table
      phase_sizes[2] = 5'd0;
      phase_sizes[3] = 5'd1;
      phase_sizes[4] = 5'd17;
      phase_sizes[5] = 5'($urandom_range(2, 15));
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: three slots, the lowest of two duplicates must win
      write_table_count(5'd3);
      queue_load(4'd0, 32'h0000_0000);
      queue_load(4'd1, 32'h9FFF_FFFF);
      queue_load(4'd2, 32'h9FFF_FFFF);
      queue_byte(KIND_UNUSED, 8'hFF);
      queue_byte(crx_pkg::KIND_NEXT, 8'hAA);        // stray byte while idle
      // standard id 0, EID bytes ignored, zero length
      queue_byte(crx_pkg::KIND_FIRST, 8'h00);
      queue_byte(crx_pkg::KIND_NEXT, 8'h00);
      queue_byte(crx_pkg::KIND_NEXT, 8'hFF);
      queue_byte(crx_pkg::KIND_NEXT, 8'hFF);
      queue_byte(crx_pkg::KIND_NEXT, 8'hF0);
      // largest extended id, length nibble 15 clamps to eight data bytes
      queue_byte(crx_pkg::KIND_FIRST, 8'hFF);
      queue_byte(crx_pkg::KIND_NEXT, 8'hFF);
      queue_byte(crx_pkg::KIND_NEXT, 8'hFF);
      queue_byte(crx_pkg::KIND_NEXT, 8'hFF);
      queue_byte(crx_pkg::KIND_NEXT, 8'h0F);
      for (int k = 0; k < 8; k++) begin
         queue_byte(crx_pkg::KIND_NEXT, BOUNDARY_DATA[63 - 8*k -: 8]);
      end
      // frame abandoned after SIDL, then standard 0x7FF which misses
      queue_byte(crx_pkg::KIND_FIRST, 8'h12);
      queue_byte(crx_pkg::KIND_NEXT, 8'h34);
      queue_byte(crx_pkg::KIND_FIRST, 8'hFF);
      queue_byte(crx_pkg::KIND_NEXT, 8'hE0);
      queue_byte(crx_pkg::KIND_NEXT, 8'h00);
      queue_byte(crx_pkg::KIND_NEXT, 8'h00);
      settle();

      // fill every slot before any size above three is used
      for (int k = 0; k < crx_pkg::CRX_TABLE_DEPTH; k++) queue_load(4'(k), table_value());
      queue_random_phase(PHASE_BEATS + crx_pkg::CRX_TABLE_DEPTH);
      foreach (phase_sizes[p]) begin
         settle();
         write_table_count(phase_sizes[p]);
         queue_random_phase(PHASE_BEATS);
      end
      settle();

      while (match_reports.size() != 0) begin
         want_beat = match_reports.pop_front();
         if (log_mismatch())
            $display("missing result beat: %s", beat_text(want_beat));
      end
      $display("covered %0d input beats and %0d result beats: %0d id hits, %0d misses, %0d data",
               beats_in, beats_out, id_hits, id_misses, data_beats);
      $display("over %0d table_count settings with %0d full drain pauses; %0d mismatches",
               sizes_used, drain_pauses, mismatches);
      if (mismatches == 0) begin
         $display("can_rx_id_match_parser_tb: done, clean");
      end else begin
         $display("can_rx_id_match_parser_tb: done, errors");
      end
      $finish;
   end

endmodule

[sim.f]
src/crx_pkg.sv
src/crx_ram.sv
src/crx_dpath.sv
src/crx_ctrl.sv
src/can_rx_id_match_parser.sv
sim/can_rx_id_match_parser_tb.sv
